>>> rtl/ipv4fht_pkg.sv
// Shared types and constants for the IPv4 fragment hole tracker.
package ipv4fht_pkg;

	localparam int POS_W = 9;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MALFORMED = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_LEFT      = 3'd3;
	localparam logic [2:0] ST_RIGHT     = 3'd4;
	localparam logic [2:0] ST_BOTH      = 3'd5;
	localparam logic [2:0] ST_UNUSED    = 3'd6;

	localparam logic [19:0] RECEIVED_MAX = 20'hFFFFF;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
	localparam logic [23:0] CAPTURE_MAX  = 24'hFFFFFF;

	typedef struct packed {
		logic [15:0] lo;
		logic [15:0] hi;
	} hole_t;

	typedef enum logic [2:0] {
		HOP_NONE,
		HOP_CLEAR,
		HOP_WRITE,
		HOP_SPLIT,
		HOP_DELETE
	} hole_op_t;

	typedef struct packed {
		hole_op_t         op;
		logic [POS_W-1:0] pos;
		hole_t            wa;
		hole_t            wb;
	} hole_ctl_t;

endpackage

>>> rtl/ipv4fht_hole_cell.sv
// One hole table entry; shifts to and from its neighbors on split and delete.
module ipv4fht_hole_cell #(
	parameter int IDX = 0,
	parameter int MAX_DATAGRAM = 65535
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipv4fht_pkg::hole_ctl_t ctl,
	input  ipv4fht_pkg::hole_t    prev,
	input  ipv4fht_pkg::hole_t    next,
	output ipv4fht_pkg::hole_t    entry
);
	import ipv4fht_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	hole_t entry_q;
	hole_t entry_d;

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			HOP_CLEAR: begin
				if (IDX == 0) begin
					entry_d.lo = '0;
					entry_d.hi = 16'(MAX_DATAGRAM);
				end
			end
			HOP_WRITE: begin
				if (MY_POS == ctl.pos) entry_d = ctl.wa;
			end
			HOP_SPLIT: begin
				if (MY_POS == ctl.pos) entry_d = ctl.wa;
				else if (MY_POS == ctl.pos + POS_W'(1)) entry_d = ctl.wb;
				else if (MY_POS > ctl.pos + POS_W'(1)) entry_d = prev;
			end
			HOP_DELETE: begin
				if (MY_POS >= ctl.pos) entry_d = next;
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.lo <= '0;
			entry_q.hi <= (IDX == 0) ? 16'(MAX_DATAGRAM) : '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

>>> rtl/ipv4_fragment_hole_tracker_top.sv
// Top level of the IPv4 fragment hole tracker.
// Usage: one input item per fragment header (command 0) or datagram clear
// (command 1), on a valid/ready channel. Each item gives exactly one result
// item on the output valid/ready channel: status, complete flag and counters.
// Steps: a clear or a fragment failing the length checks goes from the
// idle state to the done state, then its result is loaded. A valid fragment
// is checked in the idle state, scans the offset table (one entry a cycle),
// walks the hole table (one hole visited a cycle, plus a step to end it),
// then loads the result into the output register.
// The hole table is a row of cells that shift entries toward or away from
// their neighbors when a hole is split or removed.
// A new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the finished item waits in the last
// state until the output register frees up.
// Reset: asynchronous, restores one hole spanning the whole datagram, an
// empty offset table and zero counters.
module ipv4_fragment_hole_tracker_top #(
	parameter int MAX_FRAGMENTS = 32,
	parameter int MAX_HOLES = 16,
	parameter int MAX_DATAGRAM = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [3:0]  header_words,
	input  logic [15:0] total_length,
	input  logic [12:0] offset_units,
	input  logic        more_fragments,
	input  logic [15:0] captured_length,
	input  logic [15:0] packet_capture_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        complete,
	output logic [15:0] datagram_extent,
	output logic [19:0] received_bytes,
	output logic [15:0] fragment_count,
	output logic [23:0] capture_total
);
	import ipv4fht_pkg::*;

	localparam int FW = $clog2(MAX_FRAGMENTS);
	localparam int CW = $clog2(MAX_HOLES + 1);
	localparam int IW = CW + 1;
	localparam int PW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam logic [FW-1:0] SCAN_LAST = FW'(MAX_FRAGMENTS - 2);
	localparam logic [FW-1:0] SLOT_LAST = FW'(MAX_FRAGMENTS - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_WALK = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic              used_q [MAX_FRAGMENTS];
	logic [15:0]       offv_q [MAX_FRAGMENTS];
	logic [FW-1:0]     scan_q;
	logic [CW-1:0]     hcnt_q;
	logic [IW-1:0]     hidx_q;
	logic [15:0]       loff_q, plen_q, roff_q;
	logic              mf_q, unused_q;
	logic [2:0]        ovl_q, res_q;
	logic [15:0]       extent_q, count_q;
	logic [19:0]       recv_q;
	logic [23:0]       capt_q;
	logic              ov_q;
	logic [2:0]        st_q;
	logic              cmp_q;
	logic [15:0]       ext_out_q, cnt_out_q;
	logic [19:0]       rcv_out_q;
	logic [23:0]       cap_out_q;

	hole_ctl_t ctl;
	hole_t     holes [MAX_HOLES];
	hole_t     cur;

	genvar g;
	generate
		for (g = 0; g < MAX_HOLES; g++) begin : g_cell
			ipv4fht_hole_cell #(.IDX(g), .MAX_DATAGRAM(MAX_DATAGRAM)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (ctl),
				.prev  (holes[(g == 0) ? 0 : g - 1]),
				.next  (holes[(g == MAX_HOLES - 1) ? g : g + 1]),
				.entry (holes[g])
			);
		end
	endgenerate

	// length checks on the input item
	logic [5:0]  hl;
	logic [15:0] plen_in;
	logic [16:0] end_in;
	logic [15:0] off_in;
	logic        bad_in;

	always_comb begin
		hl      = {header_words, 2'b00};
		off_in  = {offset_units, 3'b000};
		plen_in = total_length - 16'(hl);
		end_in  = {1'b0, off_in} + {1'b0, plen_in};
		bad_in  = (hl < 6'd20) || (16'(hl) > captured_length) ||
			(total_length < 16'(hl)) || (total_length > captured_length) ||
			(end_in > 17'(MAX_DATAGRAM));
	end

	// offset scan
	logic          scan_stop;
	logic [FW-1:0] slot;
	logic          scan_fin;
	logic [20:0]   recv_sum;

	always_comb begin
		scan_stop = !used_q[scan_q] || (offv_q[scan_q] == loff_q);
		slot      = scan_stop ? scan_q : SLOT_LAST;
		scan_fin  = scan_stop || (scan_q == SCAN_LAST);
		recv_sum  = {1'b0, recv_q} + 21'(plen_q);
	end

	// hole walk step
	logic          in_range;
	logic [PW-1:0] hsel;
	logic [POS_W-1:0] hpos;

	always_comb begin
		in_range = (hidx_q < IW'(hcnt_q)) && (hidx_q < IW'(MAX_HOLES));
		hsel     = hidx_q[PW-1:0];
		cur      = holes[hsel];
		hpos     = POS_W'(hidx_q);
	end

	logic [16:0] cnt_sum;
	logic [24:0] cap_sum;
	assign cap_sum = {1'b0, capt_q} + 25'(packet_capture_length);

	assign in_ready = (state_q == S_IDLE);
	wire accept = in_valid && in_ready;

	logic done_fire;
	assign done_fire = (state_q == S_DONE) && (!ov_q || out_ready);

	always_comb begin
		ctl.op  = HOP_NONE;
		ctl.pos = hpos;
		ctl.wa  = cur;
		ctl.wb  = cur;
		if (accept && command) begin
			ctl.op = HOP_CLEAR;
		end else if (state_q == S_WALK && in_range && !(cur.hi < loff_q) &&
				!(cur.lo > roff_q)) begin
			if (cur.lo < loff_q) begin
				ctl.wa.hi = loff_q - 16'd1;
				if (mf_q && cur.hi > roff_q) begin
					ctl.wb.lo = roff_q;
					ctl.op    = (IW'(hcnt_q) >= IW'(MAX_HOLES)) ? HOP_NONE : HOP_SPLIT;
				end else begin
					ctl.op = HOP_WRITE;
				end
			end else if (mf_q && cur.hi > roff_q) begin
				ctl.wa.lo = roff_q;
				ctl.op    = HOP_WRITE;
			end else begin
				ctl.op = HOP_DELETE;
			end
		end
	end

	assign cnt_sum = 17'(count_q) + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			for (int k = 0; k < MAX_FRAGMENTS; k++) used_q[k] <= 1'b0;
			scan_q   <= '0;
			hcnt_q   <= CW'(1);
			hidx_q   <= '0;
			unused_q <= 1'b1;
			ovl_q    <= ST_OK;
			res_q    <= ST_OK;
			extent_q <= '0;
			count_q  <= '0;
			recv_q   <= '0;
			capt_q   <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (done_fire) ov_q <= 1'b1;
			else if (out_valid && out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command) begin
							for (int k = 0; k < MAX_FRAGMENTS; k++) used_q[k] <= 1'b0;
							hcnt_q   <= CW'(1);
							extent_q <= '0;
							count_q  <= '0;
							recv_q   <= '0;
							capt_q   <= '0;
							res_q    <= ST_OK;
							state_q  <= S_DONE;
						end else if (bad_in) begin
							res_q   <= ST_MALFORMED;
							state_q <= S_DONE;
						end else begin
							if (count_q != COUNT_MAX) count_q <= cnt_sum[15:0];
							capt_q <= cap_sum[24] ? CAPTURE_MAX : cap_sum[23:0];
							if (end_in[15:0] > extent_q) extent_q <= end_in[15:0];
							scan_q  <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_fin) begin
						if (used_q[slot]) begin
							res_q   <= ST_DUPLICATE;
							state_q <= S_DONE;
						end else begin
							used_q[slot] <= 1'b1;
							recv_q   <= recv_sum[20] ? RECEIVED_MAX : recv_sum[19:0];
							hidx_q   <= '0;
							unused_q <= 1'b1;
							ovl_q    <= ST_OK;
							state_q  <= S_WALK;
						end
					end else begin
						scan_q <= scan_q + FW'(1);
					end
				end
				S_WALK: begin
					if (!in_range || (!(cur.hi < loff_q) && cur.lo > roff_q)) begin
						res_q   <= unused_q ? ST_UNUSED : ovl_q;
						state_q <= S_DONE;
					end else if (cur.hi < loff_q) begin
						hidx_q <= hidx_q + IW'(1);
					end else if (cur.lo < loff_q) begin
						if (mf_q && cur.hi > roff_q) begin
							if (IW'(hcnt_q) >= IW'(MAX_HOLES)) begin
								res_q   <= ST_MALFORMED;
								state_q <= S_DONE;
							end else begin
								hcnt_q   <= hcnt_q + CW'(1);
								unused_q <= 1'b0;
								hidx_q   <= hidx_q + IW'(2);
							end
						end else begin
							if (roff_q > cur.hi) ovl_q <= ST_RIGHT;
							unused_q <= 1'b0;
							hidx_q   <= hidx_q + IW'(1);
						end
					end else if (mf_q && cur.hi > roff_q) begin
						if (loff_q < cur.lo) ovl_q <= ST_LEFT;
						unused_q <= 1'b0;
						hidx_q   <= hidx_q + IW'(1);
					end else begin
						if (cur.lo > loff_q && cur.hi < roff_q) ovl_q <= ST_BOTH;
						hcnt_q   <= hcnt_q - CW'(1);
						unused_q <= 1'b0;
					end
				end
				S_DONE: begin
					if (done_fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && !command) begin
			loff_q <= off_in;
			plen_q <= plen_in;
			roff_q <= end_in[15:0];
			mf_q   <= more_fragments;
		end
		if (state_q == S_SCAN && scan_fin && !used_q[slot]) offv_q[slot] <= loff_q;
		if (state_q == S_DONE && (!ov_q || out_ready)) begin
			st_q      <= res_q;
			cmp_q     <= (hcnt_q == '0) && (recv_q >= 20'(extent_q));
			ext_out_q <= extent_q;
			rcv_out_q <= recv_q;
			cnt_out_q <= count_q;
			cap_out_q <= capt_q;
		end
	end

	assign out_valid       = ov_q;
	assign status          = st_q;
	assign complete        = cmp_q;
	assign datagram_extent = ext_out_q;
	assign received_bytes  = rcv_out_q;
	assign fragment_count  = cnt_out_q;
	assign capture_total   = cap_out_q;

endmodule

>>> tb/sv/ipv4_fragment_hole_tracker_checker.sv
// Checker for the IPv4 fragment hole tracker: predicts each result and compares.
module ipv4_fragment_hole_tracker_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        command,
	input  logic [3:0]  header_words,
	input  logic [15:0] total_length,
	input  logic [12:0] offset_units,
	input  logic        more_fragments,
	input  logic [15:0] captured_length,
	input  logic [15:0] packet_capture_length,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic        complete,
	input  logic [15:0] datagram_extent,
	input  logic [19:0] received_bytes,
	input  logic [15:0] fragment_count,
	input  logic [23:0] capture_total,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ipv4fht_pkg::*;

	localparam int NFRAG = 32;
	localparam int NHOLE = 16;
	localparam int DGRAM_MAX = 65535;

	typedef struct packed {
		logic [2:0]  status;
		logic        complete;
		logic [15:0] extent;
		logic [19:0] received;
		logic [15:0] count;
		logic [23:0] capture;
	} frag_result_t;

	frag_result_t result_q[$];
	int unsigned hole_lo[NHOLE];
	int unsigned hole_hi[NHOLE];
	int unsigned hole_cnt;
	bit off_used[NFRAG];
	int unsigned off_val[NFRAG];
	int unsigned extent_r, received_r, count_r, capture_r;

	function automatic void reset_datagram();
		for (int i = 0; i < NHOLE; i++) begin
			hole_lo[i] = 0;
			hole_hi[i] = 0;
		end
		hole_hi[0] = DGRAM_MAX;
		hole_cnt = 1;
		for (int i = 0; i < NFRAG; i++) begin
			off_used[i] = 0;
			off_val[i] = 0;
		end
		extent_r = 0;
		received_r = 0;
		count_r = 0;
		capture_r = 0;
	endfunction

	function automatic logic [2:0] walk_holes(int unsigned loff, int unsigned plen, bit mf);
		int unsigned roff;
		logic [2:0] ovl;
		bit unused;
		int unsigned i;
		roff = loff + plen;
		ovl = ST_OK;
		unused = 1;
		i = 0;
		while (i < hole_cnt && i < NHOLE) begin
			if (hole_hi[i] < loff) begin
				i++;
				continue;
			end
			if (hole_lo[i] > roff)
				break;
			if (hole_lo[i] < loff) begin
				if (mf && hole_hi[i] > roff) begin
					if (hole_cnt >= NHOLE)
						return ST_MALFORMED;
					for (int unsigned k = hole_cnt; k > i + 1; k--) begin
						hole_lo[k] = hole_lo[k-1];
						hole_hi[k] = hole_hi[k-1];
					end
					hole_lo[i+1] = roff;
					hole_hi[i+1] = hole_hi[i];
					hole_hi[i] = loff - 1;
					hole_cnt++;
					unused = 0;
					i += 2;
				end else begin
					if (roff > hole_hi[i])
						ovl = ST_RIGHT;
					hole_hi[i] = loff - 1;
					unused = 0;
					i++;
				end
			end else if (mf && hole_hi[i] > roff) begin
				if (loff < hole_lo[i])
					ovl = ST_LEFT;
				hole_lo[i] = roff;
				unused = 0;
				i++;
			end else begin
				if (hole_lo[i] > loff && hole_hi[i] < roff)
					ovl = ST_BOTH;
				for (int unsigned k = i; k + 1 < hole_cnt; k++) begin
					hole_lo[k] = hole_lo[k+1];
					hole_hi[k] = hole_hi[k+1];
				end
				hole_cnt--;
				unused = 0;
			end
		end
		return unused ? ST_UNUSED : ovl;
	endfunction

	function automatic logic [2:0] apply_fragment(logic [3:0] ihl, logic [15:0] tl,
			logic [12:0] offu, bit mf, logic [15:0] cap, logic [15:0] pcap);
		int unsigned hl, off, plen, fin, i;
		hl = ihl * 4;
		off = offu * 8;
		if (hl < 20 || hl > cap)
			return ST_MALFORMED;
		if (tl < hl || tl > cap)
			return ST_MALFORMED;
		plen = tl - hl;
		fin = off + plen;
		if (fin > DGRAM_MAX)
			return ST_MALFORMED;
		if (count_r < COUNT_MAX)
			count_r++;
		capture_r += pcap;
		if (capture_r > CAPTURE_MAX)
			capture_r = CAPTURE_MAX;
		if (fin > extent_r)
			extent_r = fin;
		for (i = 0; i + 1 < NFRAG; i++) begin
			if (!off_used[i])
				break;
			if (off_val[i] == off)
				break;
		end
		if (off_used[i])
			return ST_DUPLICATE;
		off_used[i] = 1;
		off_val[i] = off;
		received_r += plen;
		if (received_r > RECEIVED_MAX)
			received_r = RECEIVED_MAX;
		return walk_holes(off, plen, mf);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frag_result_t exp_r, got;
		if (!arst_n) begin
			reset_datagram();
			result_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (command) begin
					reset_datagram();
					exp_r.status = ST_OK;
				end else begin
					exp_r.status = apply_fragment(header_words, total_length, offset_units,
						more_fragments, captured_length, packet_capture_length);
				end
				exp_r.complete = (hole_cnt == 0 && received_r >= extent_r);
				exp_r.extent = extent_r[15:0];
				exp_r.received = received_r[19:0];
				exp_r.count = count_r[15:0];
				exp_r.capture = capture_r[23:0];
				result_q.push_back(exp_r);
			end
			if (out_valid && out_ready) begin
				got = '{status, complete, datagram_extent, received_bytes,
					fragment_count, capture_total};
				if (result_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item %p", got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = result_q.pop_front();
					if (got !== exp_r) begin
						if (fail_count < 10)
							$display("mismatch: expected %p actual %p", exp_r, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= result_q.size();
		end
	end
endmodule

>>> tb/sv/ipv4_fragment_hole_tracker_top_tb.sv
// Testbench top for the IPv4 fragment hole tracker: stimulus and verdict.
module ipv4_fragment_hole_tracker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        command = 0;
	logic [3:0]  header_words = 0;
	logic [15:0] total_length = 0;
	logic [12:0] offset_units = 0;
	logic        more_fragments = 0;
	logic [15:0] captured_length = 0;
	logic [15:0] packet_capture_length = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [2:0]  status;
	logic        complete;
	logic [15:0] datagram_extent;
	logic [19:0] received_bytes;
	logic [15:0] fragment_count;
	logic [23:0] capture_total;
	int          fail_count;
	int          pending;
	int          send_idle = 0;
	int          recv_stall = 0;
	bit          hold_off = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	ipv4_fragment_hole_tracker_top u_dut (.*);

	ipv4_fragment_hole_tracker_checker u_chk (.*);

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send_item(bit cmd, logic [3:0] ihl, logic [15:0] tl, logic [12:0] offu,
			bit mf, logic [15:0] cap, logic [15:0] pcap);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		header_words <= ihl;
		total_length <= tl;
		offset_units <= offu;
		more_fragments <= mf;
		captured_length <= cap;
		packet_capture_length <= pcap;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// well-formed fragment: IHL 5, payload in 8-byte multiples mostly
	task automatic send_frag(logic [12:0] offu, int unsigned plen, bit mf);
		logic [15:0] tl;
		tl = 16'(20 + plen);
		send_item(0, 5, tl, offu, mf, 16'(tl + $urandom_range(3)), 16'($urandom));
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 || u_chk.result_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_datagram(int n);
		int unsigned units, o, ln;
		units = $urandom_range(3) == 0 ? $urandom_range(8191) : $urandom_range(40);
		send_item(1, 4'($urandom), 16'($urandom), 13'($urandom), 1'($urandom),
			16'($urandom), 16'($urandom));
		for (int j = 0; j < n; j++) begin
			case ($urandom_range(9))
				0: send_item(0, 4'($urandom), 16'($urandom), 13'($urandom), 1'($urandom),
					16'($urandom), 16'($urandom));
				1: send_item(0, 4'($urandom_range(15)), 16'($urandom_range(200)),
					13'($urandom_range(50)), 1'($urandom), 16'($urandom_range(200)),
					16'($urandom));
				default: begin
					o = $urandom_range(units);
					ln = 8 * $urandom_range(1, 6) + ($urandom_range(4) == 0 ? $urandom_range(7) : 0);
					if (o * 8 + ln > 65535)
						o = (65535 - ln) / 8;
					send_frag(13'(o), ln, $urandom_range(4) != 0);
				end
			endcase
		end
	endtask

	initial begin
		#200_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send_frag(0, 16, 1);
		send_frag(0, 16, 1);
		send_frag(4, 8, 1);
		send_frag(1, 40, 0);
		send_frag(8, 16, 0);
		send_item(0, 4, 100, 0, 0, 100, 1);
		send_item(0, 15, 59, 0, 0, 59, 1);
		send_item(0, 15, 60, 0, 0, 60, 16'hFFFF);
		send_item(0, 5, 100, 0, 0, 99, 1);
		send_item(0, 5, 16'hFFFF, 8191, 1, 16'hFFFF, 16'hFFFF);
		send_item(0, 5, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF);
		send_frag(8191, 4, 0);
		send_item(0, 0, 0, 0, 0, 0, 0);
		send_item(1, 0, 0, 0, 0, 0, 0);
		send_frag(0, 8, 0);
		send_frag(1, 0, 0);
		send_item(1, 4'hF, 16'hFFFF, 13'h1FFF, 1, 16'hFFFF, 16'hFFFF);
		// hole table full: many splits
		for (int j = 0; j < 20; j++)
			send_frag(13'(2 + 3 * j), 8, 1);
		// offset table full
		for (int j = 0; j < 16; j++)
			send_frag(13'(200 + j), 8, 1);
		// sender pauses until everything is back
		drain();
		// long hold-off while sender keeps offering
		hold_off = 1;
		fork
			random_datagram(30);
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
		join
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 74; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 74; end
				3: begin send_idle = 37; recv_stall = 37; end
			endcase
			for (int d = 0; d < 10; d++)
				random_datagram($urandom_range(10, 40));
		end
		send_idle = 0;
		recv_stall = 0;
		drain();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

>>> sim.f
rtl/ipv4fht_pkg.sv
rtl/ipv4fht_hole_cell.sv
rtl/ipv4_fragment_hole_tracker_top.sv
tb/sv/ipv4_fragment_hole_tracker_checker.sv
tb/sv/ipv4_fragment_hole_tracker_top_tb.sv
